@@ sv/sdf_pkg.sv @@
package sdf_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int ALPHA_W    = 16;
	localparam int BETA_W     = 16;
	localparam int RECIP_W    = 24;

	// 0.4 in Q.16
	localparam logic [14:0] TAP_Q16  = 15'd26214;
	localparam logic [16:0] ONE_Q16  = 17'h10000;
	localparam logic [16:0] HALF_Q16 = 17'h08000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEAM  = 2'd0,
		CFG_FLAT  = 2'd1,
		CFG_RECIP = 2'd2
	} cfg_idx_t;

endpackage

@@ sv/seam_deblock_filter.sv @@
// Weak four-tap deblocking across one block seam. Each input beat carries p1, p0, q0, q1;
// each output beat carries the corrected samples and a filtered flag in tuser. The block
// takes one beat per clock unless stalled and passes it through a five-stage pipeline
// (threshold compare, taper and tap multiplies, weight multiply, outer-tap multiply,
// round and clamp). Each stage stalls only when the stage after it is full, so bubbles
// are squeezed out and input is still taken while a finished beat waits at the output.
// Thresholds and the reciprocal of alpha are written through the cfg channel, which is
// always ready, and must only be changed while no beat is in flight.
module seam_deblock_filter import sdf_pkg::*; #(
	parameter int SAMPLE_BITS = 8,
	localparam int IO_W = ((4 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IO_W-1:0]       s_axis_tdata,  // low_outer, low_inner, high_inner, high_outer
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [IO_W-1:0]       m_axis_tdata,  // new_low_outer, new_low_inner,
	                                             // new_high_inner, new_high_outer
	output logic [0:0]            m_axis_tuser,  // was_filtered
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SB = SAMPLE_BITS;
	localparam int VW = SB + 19;

	logic [ALPHA_W-1:0] seam_q;
	logic [BETA_W-1:0]  flat_q;
	logic [RECIP_W-1:0] recip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seam_q  <= '0;
			flat_q  <= '0;
			recip_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SEAM:  seam_q  <= cfg_data[ALPHA_W-1:0];
				CFG_FLAT:  flat_q  <= cfg_data[BETA_W-1:0];
				CFG_RECIP: recip_q <= cfg_data[RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	function automatic logic [SB-1:0] corr(input logic [SB-1:0] base, input logic neg,
			input logic [SB+15:0] mag);
		logic signed [VW-1:0] v;
		logic [VW-1:0]        sum;
		logic [SB+2:0]        r;
		v   = $signed({3'b000, base, 16'h0000});
		v   = neg ? v - $signed({3'b000, mag}) : v + $signed({3'b000, mag});
		sum = $unsigned(v) + VW'(HALF_Q16);
		r   = sum[VW-1:16];
		if (v[VW-1])
			corr = '0;
		else if (r > (SB+3)'({SB{1'b1}}))
			corr = {SB{1'b1}};
		else
			corr = r[SB-1:0];
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	assign en5 = !v_s5 || m_axis_tready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// stage 1 inputs
	logic [SB-1:0] in_p1, in_p0, in_q0, in_q1;
	logic [SB-1:0] in_ad, in_apd, in_aqd;
	logic          in_filt;

	assign in_p1  = s_axis_tdata[SB-1:0];
	assign in_p0  = s_axis_tdata[2*SB-1:SB];
	assign in_q0  = s_axis_tdata[3*SB-1:2*SB];
	assign in_q1  = s_axis_tdata[4*SB-1:3*SB];
	assign in_ad  = (in_q0 >= in_p0) ? in_q0 - in_p0 : in_p0 - in_q0;
	assign in_apd = (in_p1 >= in_p0) ? in_p1 - in_p0 : in_p0 - in_p1;
	assign in_aqd = (in_q1 >= in_q0) ? in_q1 - in_q0 : in_q0 - in_q1;
	assign in_filt = (in_ad != '0)
		&& ({in_ad, 8'h00} < (SB+8)'(seam_q))
		&& ({in_apd, 8'h00} < (SB+8)'(flat_q))
		&& ({in_aqd, 8'h00} < (SB+8)'(flat_q));

	logic [SB-1:0] p1_s1, p0_s1, q0_s1, q1_s1, ad_s1;
	logic          neg_s1, filt_s1;
	logic [SB-1:0] p1_s2, p0_s2, q0_s2, q1_s2;
	logic          neg_s2;
	logic [SB+23:0] t_s2;
	logic [SB+14:0] adk_s2;
	logic [SB-1:0] p1_s3, p0_s3, q0_s3, q1_s3;
	logic          neg_s3;
	logic [SB+31:0] prod0_s3;
	logic [SB-1:0] p1_s4, p0_s4, q0_s4, q1_s4;
	logic          neg_s4;
	logic [SB+15:0] m0_s4;
	logic [SB+30:0] prod1_s4;
	logic [SB-1:0] p1_s5, p0_s5, q0_s5, q1_s5;
	logic          filt_s5;

	logic [16:0]    w;
	logic [SB+15:0] m1;

	assign w  = (t_s2[SB+23:16] != '0) ? 17'd0 : ONE_Q16 - {1'b0, t_s2[15:0]};
	assign m1 = {1'b0, prod1_s4[SB+30:16]};

	always_ff @(posedge clk) begin
		if (en1 && s_axis_tvalid) begin
			p1_s1   <= in_p1;
			p0_s1   <= in_p0;
			q0_s1   <= in_q0;
			q1_s1   <= in_q1;
			ad_s1   <= in_ad;
			neg_s1  <= in_q0 < in_p0;
			filt_s1 <= in_filt;
		end
		if (en2 && v_s1) begin
			{p1_s2, p0_s2, q0_s2, q1_s2} <= {p1_s1, p0_s1, q0_s1, q1_s1};
			neg_s2 <= neg_s1;
			t_s2   <= (SB+24)'(ad_s1) * (SB+24)'(recip_q);
			adk_s2 <= filt_s1 ? (SB+15)'(ad_s1) * (SB+15)'(TAP_Q16) : '0;
		end
		if (en3 && v_s2) begin
			{p1_s3, p0_s3, q0_s3, q1_s3} <= {p1_s2, p0_s2, q0_s2, q1_s2};
			neg_s3   <= neg_s2;
			prod0_s3 <= (SB+32)'(adk_s2) * (SB+32)'(w);
		end
		if (en4 && v_s3) begin
			{p1_s4, p0_s4, q0_s4, q1_s4} <= {p1_s3, p0_s3, q0_s3, q1_s3};
			neg_s4   <= neg_s3;
			m0_s4    <= prod0_s3[SB+31:16];
			prod1_s4 <= (SB+31)'(prod0_s3[SB+31:16]) * (SB+31)'(TAP_Q16);
		end
		if (en5 && v_s4) begin
			filt_s5 <= m0_s4 != '0;
			if (m0_s4 == '0) begin
				{p1_s5, p0_s5, q0_s5, q1_s5} <= {p1_s4, p0_s4, q0_s4, q1_s4};
			end else begin
				p1_s5 <= corr(p1_s4, neg_s4, m1);
				p0_s5 <= corr(p0_s4, neg_s4, m0_s4);
				q0_s5 <= corr(q0_s4, !neg_s4, m0_s4);
				q1_s5 <= corr(q1_s4, !neg_s4, m1);
			end
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = IO_W'({q1_s5, q0_s5, p0_s5, p1_s5});
	assign m_axis_tuser  = filt_s5;

	a_free_out_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output stage");

	a_zero_step_no_filter: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && ad_s1 == '0) |-> !filt_s1)
		else $error("zero step marked for filtering");

	a_gated_tap: assert property (@(posedge clk) disable iff (!arst_n)
		(en2 && v_s1 && !filt_s1) |=> (adk_s2 == '0))
		else $error("tap product not gated for unfiltered beat");

	a_passthrough: assert property (@(posedge clk) disable iff (!arst_n)
		(en5 && v_s4 && m0_s4 == '0) |=>
		(!m_axis_tuser[0] && p0_s5 == $past(p0_s4) && q1_s5 == $past(q1_s4)))
		else $error("unfiltered beat altered");

	a_filtered_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(en5 && v_s4 && m0_s4 != '0) |=> m_axis_tuser[0])
		else $error("filtered beat not flagged");

endmodule

@@ tb/sv/tb_seam_deblock_filter.sv @@
module tb_seam_deblock_filter;
	import sdf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_BITS = 8;
	localparam int IO_W = ((4 * SAMPLE_BITS + 7) / 8) * 8;
	localparam longint SAMPLE_MAX = (64'd1 << SAMPLE_BITS) - 1;
	localparam longint unsigned TAP_WEIGHT = 26214;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT = 200000;

	// lowest field last: low_outer sits in bits [7:0]
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] high_outer;
		logic [SAMPLE_BITS-1:0] high_inner;
		logic [SAMPLE_BITS-1:0] low_inner;
		logic [SAMPLE_BITS-1:0] low_outer;
	} seam_quad_t;

	typedef struct {
		seam_quad_t samples;
		logic       was_filtered;
	} seam_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IO_W-1:0]       s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [IO_W-1:0]       m_axis_tdata;
	logic [0:0]            m_axis_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index = CFG_SEAM;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [15:0] seam_alpha = '0;
	logic [15:0] flat_beta = '0;
	logic [23:0] alpha_recip = '0;

	seam_result_t corrected_quads[$];
	int mismatches = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	seam_deblock_filter #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic longint unsigned gap(input logic [SAMPLE_BITS-1:0] a,
			input logic [SAMPLE_BITS-1:0] b);
		return (a >= b) ? 64'(a - b) : 64'(b - a);
	endfunction

	// base +/- mag (Q.16), rounded half away from zero, clamped
	function automatic logic [SAMPLE_BITS-1:0] nudge(input logic [SAMPLE_BITS-1:0] base,
			input logic down, input longint unsigned mag);
		longint v;
		longint r;
		v = longint'(base) * 65536;
		if (down)
			v = v - longint'(mag);
		else
			v = v + longint'(mag);
		if (v >= 0)
			r = (v + 32768) / 65536;
		else
			r = -((32768 - v) / 65536);
		if (r < 0)
			r = 0;
		if (r > SAMPLE_MAX)
			r = SAMPLE_MAX;
		return r[SAMPLE_BITS-1:0];
	endfunction

	function automatic seam_result_t deblock_quad(input seam_quad_t s);
		seam_result_t res;
		longint unsigned step;
		longint unsigned t;
		longint unsigned w;
		longint unsigned m0;
		longint unsigned m1;
		logic down;
		step = gap(s.high_inner, s.low_inner);
		down = s.high_inner < s.low_inner;
		m0 = 0;
		m1 = 0;
		if (step != 0 && step * 256 < seam_alpha &&
				gap(s.low_outer, s.low_inner) * 256 < flat_beta &&
				gap(s.high_outer, s.high_inner) * 256 < flat_beta) begin
			t = step * alpha_recip;
			w = (t >= 65536) ? 0 : 65536 - t;
			m0 = (step * TAP_WEIGHT * w) >> 16;
			m1 = (m0 * TAP_WEIGHT) >> 16;
		end
		res.samples = s;
		res.was_filtered = 1'b0;
		if (m0 != 0) begin
			res.was_filtered = 1'b1;
			res.samples.low_outer  = nudge(s.low_outer, down, m1);
			res.samples.low_inner  = nudge(s.low_inner, down, m0);
			res.samples.high_inner = nudge(s.high_inner, !down, m0);
			res.samples.high_outer = nudge(s.high_outer, !down, m1);
		end
		return res;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] clip(input int v);
		if (v < 0)
			return '0;
		if (v > SAMPLE_MAX)
			return SAMPLE_MAX[SAMPLE_BITS-1:0];
		return v[SAMPLE_BITS-1:0];
	endfunction

	task automatic check_field(input string label, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t %s: expected %0d, got %0d", $time, label, want, got);
		end
	endtask

	always @(posedge clk) begin : check_beats
		seam_quad_t got;
		seam_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (corrected_quads.size() == 0) begin
				mismatches++;
				$display("%0t unexpected beat: expected none, got tdata %h tuser %b",
					$time, m_axis_tdata, m_axis_tuser);
			end else begin
				want = corrected_quads.pop_front();
				check_field("new_low_outer", 64'(want.samples.low_outer),
					64'(got.low_outer));
				check_field("new_low_inner", 64'(want.samples.low_inner),
					64'(got.low_inner));
				check_field("new_high_inner", 64'(want.samples.high_inner),
					64'(got.high_inner));
				check_field("new_high_outer", 64'(want.samples.high_outer),
					64'(got.high_outer));
				check_field("was_filtered", 64'(want.was_filtered), 64'(m_axis_tuser[0]));
			end
		end
	end

	// call at a rising edge; returns at the edge that took the beat
	task automatic send_quad(input seam_quad_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= s;
		do @(posedge clk); while (!s_axis_tready);
		corrected_quads.push_back(deblock_quad(s));
	endtask

	task automatic send_samples(input int p1, input int p0, input int q0, input int q1);
		seam_quad_t s;
		s.low_outer = SAMPLE_BITS'(p1);
		s.low_inner = SAMPLE_BITS'(p0);
		s.high_inner = SAMPLE_BITS'(q0);
		s.high_outer = SAMPLE_BITS'(q1);
		send_quad(s);
	endtask

	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		while (corrected_quads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SEAM: seam_alpha = value[15:0];
			CFG_FLAT: flat_beta = value[15:0];
			CFG_RECIP: alpha_recip = value[23:0];
			default: ;
		endcase
	endtask

	task automatic set_thresholds(input logic [23:0] alpha, input logic [23:0] beta,
			input logic [23:0] recip);
		cfg_write(CFG_SEAM, alpha);
		cfg_write(CFG_FLAT, beta);
		cfg_write(CFG_RECIP, recip);
		cfg_valid <= 1'b0;
	endtask

	task automatic pick_random_thresholds();
		logic [23:0] alpha;
		logic [23:0] beta;
		logic [23:0] recip;
		alpha = 24'($urandom);
		beta = 24'($urandom);
		if ($urandom_range(3) != 0) begin
			alpha[15:8] = 8'($urandom_range(48, 1));
			beta[15:8] = 8'($urandom_range(16, 0));
		end
		if (alpha[15:0] != 0 && $urandom_range(3) != 0)
			recip = 24'((64'd16777216 + alpha[15:0] / 2) / alpha[15:0]);
		else
			recip = 24'($urandom);
		set_thresholds(alpha, beta, recip);
	endtask

	// mostly quads with steps up to just past the thresholds, the rest anything
	task automatic send_random_quad();
		seam_quad_t s;
		int reach;
		int spread;
		int step;
		s = seam_quad_t'($urandom);
		if ($urandom_range(3) != 0) begin
			reach = int'(seam_alpha[15:8]) + 1;
			spread = int'(flat_beta[15:8]) + 1;
			step = int'($urandom_range(reach, 1));
			if ($urandom_range(1))
				step = -step;
			s.high_inner = clip(int'(s.low_inner) + step);
			s.low_outer = clip(int'(s.low_inner) + int'($urandom_range(2 * spread)) - spread);
			s.high_outer = clip(int'(s.high_inner) + int'($urandom_range(2 * spread)) - spread);
		end
		send_quad(s);
	endtask

	// alpha still zero from reset: everything passes through
	task automatic test_reset_bypass();
		send_samples(0, 0, 255, 255);
		send_samples(255, 255, 0, 0);
		send_samples(12, 10, 20, 22);
		send_samples(0, 0, 0, 0);
		send_samples(255, 255, 255, 255);
	endtask

	// widest thresholds, untapered weight: clamping and zero step
	task automatic test_full_taper();
		drain_pipeline();
		set_thresholds(24'h00FFFF, 24'h00FFFF, 24'h000000);
		send_samples(255, 0, 255, 0);
		send_samples(0, 255, 0, 255);
		send_samples(255, 250, 255, 255);
		send_samples(0, 5, 0, 0);
		send_samples(100, 100, 101, 101);
		send_samples(7, 7, 7, 7);
		send_samples(0, 128, 128, 255);
	endtask

	// reciprocal too large for alpha: weight floors at zero or truncates away
	task automatic test_weight_floor();
		drain_pipeline();
		set_thresholds(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
		send_samples(10, 10, 11, 11);
		send_samples(200, 200, 0, 0);
		drain_pipeline();
		set_thresholds(24'h00FFFF, 24'h00FFFF, 24'h00FFFF);
		send_samples(10, 10, 11, 11);
		send_samples(0, 0, 2, 2);
	endtask

	// alpha 40.0, beta 8.0: both sides of each threshold
	task automatic test_threshold_edges();
		drain_pipeline();
		set_thresholds(24'h002800, 24'h000800, 24'd1638);
		send_samples(50, 50, 60, 60);
		send_samples(60, 60, 50, 50);
		send_samples(50, 50, 90, 90);
		send_samples(50, 50, 89, 89);
		send_samples(42, 50, 60, 60);
		send_samples(43, 50, 60, 60);
		send_samples(50, 50, 60, 68);
		send_samples(0, 0, 10, 10);
		send_samples(255, 255, 245, 245);
	endtask

	task automatic test_random_stream(input int idle_pct, input int stall_pct, input int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (2) begin
			drain_pipeline();
			pick_random_thresholds();
			repeat (count / 2) send_random_quad();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_bypass();
		test_full_taper();
		test_weight_floor();
		test_threshold_edges();
		test_random_stream(0, 0, 126);
		test_random_stream(73, 0, 126);
		test_random_stream(0, 73, 126);
		test_random_stream(6, 6, 126);
		drain_pipeline();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
